FILE: rtl/core/smw_pkg.sv
// Shared types and constants of the sign-magnitude wide ALU.
// No dependencies; imported by the ALU top level, the MAC and the divider.
package smw_pkg;

  localparam int unsigned WordW          = 64;
  localparam int unsigned LimbW          = 32;
  localparam int unsigned OperandWordsDef = 8;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_REM = 3'd4
  } op_e;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SETUP  = 9'b000000010,
    S_ADD    = 9'b000000100,
    S_ADD2   = 9'b000001000,
    S_MUL    = 9'b000010000,
    S_DIV    = 9'b000100000,
    S_DIVOUT = 9'b001000000,
    S_FIN    = 9'b010000000,
    S_EMIT   = 9'b100000000
  } state_e;

  typedef struct packed {
    logic issue;
    logic col_end;
  } mac_ctl_t;

endpackage

FILE: rtl/core/smw_mac.sv
// Shared 32x32 multiply-accumulate unit for column-wise wide multiplication.
// Depends on smw_pkg.
module smw_mac #(
  parameter int unsigned AccW = 70
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clear_i,
  input  smw_pkg::mac_ctl_t        ctl_i,
  input  logic [smw_pkg::LimbW-1:0] x_i,
  input  logic [smw_pkg::LimbW-1:0] y_i,
  output logic                     limb_valid_o,
  output logic [smw_pkg::LimbW-1:0] limb_o
);
  import smw_pkg::*;

  logic [2*LimbW-1:0] prod_q;
  mac_ctl_t           ctl_q;
  logic [AccW-1:0]    acc_q, acc_d, sum;

  assign sum = acc_q + AccW'(prod_q);

  always_comb begin
    acc_d = acc_q;
    if (ctl_q.issue) begin
      acc_d = ctl_q.col_end ? (sum >> LimbW) : sum;
    end
    if (clear_i) begin
      acc_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= clear_i ? '0 : ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= x_i * y_i;
    acc_q  <= acc_d;
  end

  assign limb_valid_o = ctl_q.issue & ctl_q.col_end;
  assign limb_o       = sum[LimbW-1:0];

endmodule

FILE: rtl/core/smw_div.sv
// Restoring bit-serial divider: one shift-subtract step per cycle while step_i is high.
// Depends on smw_pkg.
module smw_div #(
  parameter int unsigned TotW = 512
) (
  input  logic            clk_i,
  input  logic            load_i,
  input  logic            step_i,
  input  logic [TotW-1:0] dividend_i,
  input  logic [TotW-1:0] divisor_i,
  output logic [TotW-1:0] quo_o,
  output logic [TotW-1:0] rem_o
);
  import smw_pkg::*;

  logic [TotW-1:0] rem_q, quo_q;
  logic [TotW:0]   sh;
  logic [TotW+1:0] diff;
  logic            ge;

  assign sh   = {rem_q, quo_q[TotW-1]};
  assign diff = {1'b0, sh} - {2'b00, divisor_i};
  assign ge   = ~diff[TotW+1];

  // quotient bits shift in as dividend bits shift out
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (step_i) begin
      rem_q <= ge ? diff[TotW-1:0] : sh[TotW-1:0];
      quo_q <= {quo_q[TotW-2:0], ge};
    end
  end

  assign quo_o = quo_q;
  assign rem_o = rem_q;

endmodule

FILE: rtl/core/sign_magnitude_wide_alu.sv
// Channel   | ports                                              | handshake
// ----------+----------------------------------------------------+------------------------
// operands  | opcode_i a_word_i b_word_i a/b_negative_i a/b_nan_i | start & !busy
//           | last_in_i                                          |
// results   | result_word_o result_negative_o result_nan_o       | valid_o, one cycle each
//           | last_out_o                                         |
// Each item loads one word pair. The item with last_in_i runs the operation:
// add/sub on a word-serial 64-bit adder (second pass when |b|>|a|), multiply
// with one 32x32 product per cycle, divide/remainder with one 64W-bit
// shift-subtract per cycle, then W result words, one per cycle.
// busy is high from the last item to the last result word. Reset clears control
// only; the receiver cannot stall, so results leave on consecutive cycles.
module sign_magnitude_wide_alu #(
  parameter int unsigned OPERAND_WORDS = smw_pkg::OperandWordsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                opcode_i,
  input  logic [smw_pkg::WordW-1:0] a_word_i,
  input  logic [smw_pkg::WordW-1:0] b_word_i,
  input  logic                      a_negative_i,
  input  logic                      b_negative_i,
  input  logic                      a_nan_i,
  input  logic                      b_nan_i,
  input  logic                      last_in_i,
  output logic                      valid_o,
  output logic [smw_pkg::WordW-1:0] result_word_o,
  output logic                      result_negative_o,
  output logic                      result_nan_o,
  output logic                      last_out_o
);
  import smw_pkg::*;

  localparam int unsigned TotW   = OPERAND_WORDS * WordW;
  localparam int unsigned LimbN  = 2 * OPERAND_WORDS;
  localparam int unsigned IdxW   = $clog2(OPERAND_WORDS);
  localparam int unsigned LW     = $clog2(LimbN);
  localparam int unsigned CW     = $clog2(2 * LimbN);
  localparam int unsigned DW     = $clog2(TotW);
  localparam int unsigned AccW   = 2 * LimbW + LW + 1;

  logic [WordW-1:0] a_store_q [OPERAND_WORDS];
  logic [WordW-1:0] b_store_q [OPERAND_WORDS];
  logic [TotW-1:0]  a_flat, b_flat;

  state_e          state_q, state_d;
  logic [IdxW-1:0] load_q;
  logic [2:0]      op_q;
  logic            an_q, bn_q, nanin_q;
  logic            neg_q, nan_q, carry_q, swap_q;
  logic [TotW-1:0] wa_q, wb_q, res_q;
  logic [DW-1:0]   cnt_q;
  logic [LW-1:0]   li_q;
  logic [CW-1:0]   col_q, oc_q;
  logic            issue_q;

  logic            accept;
  logic            bzero, eff_sub;
  logic [WordW-1:0] ax, by;
  logic [WordW:0]  sum;
  logic [CW-1:0]   jw;
  logic            in_rng;
  logic [LimbW-1:0] mx, my, limb;
  logic            limb_valid, mac_clear;
  mac_ctl_t        mac_ctl;
  logic            div_load, div_step;
  logic [TotW-1:0] quo, remd;

  for (genvar g = 0; g < OPERAND_WORDS; g++) begin : g_flat
    assign a_flat[g*WordW +: WordW] = a_store_q[g];
    assign b_flat[g*WordW +: WordW] = b_store_q[g];
  end

  assign busy   = (state_q != S_IDLE);
  assign accept = start & ~busy;
  assign bzero  = ~|b_flat;
  assign eff_sub = an_q ^ bn_q ^ (op_q == OP_SUB);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_store_q[load_q] <= a_word_i;
      b_store_q[load_q] <= b_word_i;
    end
  end

  // word-serial adder; the operand registers rotate so a second pass sees them again
  assign ax  = swap_q ? wb_q[WordW-1:0] : wa_q[WordW-1:0];
  assign by  = swap_q ? wa_q[WordW-1:0] : wb_q[WordW-1:0];
  assign sum = {1'b0, ax} + {1'b0, (eff_sub ? ~by : by)} + (WordW+1)'(carry_q);

  // limb selection for the current column product
  assign jw      = col_q - CW'(li_q);
  assign in_rng  = (col_q >= CW'(li_q)) && (jw < CW'(LimbN));
  assign mx      = in_rng ? wa_q[li_q*LimbW +: LimbW] : '0;
  assign my      = in_rng ? wb_q[jw[LW-1:0]*LimbW +: LimbW] : '0;
  assign mac_ctl.issue   = issue_q;
  assign mac_ctl.col_end = (li_q == LW'(LimbN - 1));
  assign mac_clear = (state_q == S_SETUP);

  smw_mac #(.AccW(AccW)) u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (mac_clear),
    .ctl_i        (mac_ctl),
    .x_i          (mx),
    .y_i          (my),
    .limb_valid_o (limb_valid),
    .limb_o       (limb)
  );

  assign div_load = (state_q == S_SETUP);
  assign div_step = (state_q == S_DIV);

  smw_div #(.TotW(TotW)) u_div (
    .clk_i      (clk_i),
    .load_i     (div_load),
    .step_i     (div_step),
    .dividend_i (a_flat),
    .divisor_i  (b_flat),
    .quo_o      (quo),
    .rem_o      (remd)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (accept && last_in_i) state_d = S_SETUP;
      S_SETUP: begin
        if (nanin_q || op_q > OP_REM || ((op_q inside {OP_DIV, OP_REM}) && bzero)) begin
          state_d = S_FIN;
        end else begin
          case (op_q)
            OP_ADD, OP_SUB: state_d = S_ADD;
            OP_MUL:         state_d = S_MUL;
            default:        state_d = S_DIV;
          endcase
        end
      end
      S_ADD: begin
        if (cnt_q == DW'(OPERAND_WORDS - 1)) begin
          state_d = (eff_sub && !sum[WordW]) ? S_ADD2 : S_FIN;
        end
      end
      S_ADD2:   if (cnt_q == DW'(OPERAND_WORDS - 1)) state_d = S_FIN;
      S_MUL:    if (limb_valid && oc_q == CW'(2 * LimbN - 1)) state_d = S_FIN;
      S_DIV:    if (cnt_q == DW'(TotW - 1)) state_d = S_DIVOUT;
      S_DIVOUT: state_d = S_FIN;
      S_FIN:    state_d = S_EMIT;
      S_EMIT:   if (cnt_q == DW'(OPERAND_WORDS - 1)) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      load_q  <= '0;
      issue_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        if (last_in_i || load_q == IdxW'(OPERAND_WORDS - 1)) load_q <= '0;
        else load_q <= load_q + 1'b1;
      end
      if (state_q == S_SETUP) issue_q <= (state_d == S_MUL);
      else if (issue_q && mac_ctl.col_end && col_q == CW'(2 * LimbN - 1)) issue_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last_in_i) begin
      op_q    <= opcode_i;
      an_q    <= a_negative_i;
      bn_q    <= b_negative_i;
      nanin_q <= a_nan_i | b_nan_i;
    end
    case (state_q)
      S_SETUP: begin
        wa_q    <= a_flat;
        wb_q    <= b_flat;
        res_q   <= '0;
        cnt_q   <= '0;
        li_q    <= '0;
        col_q   <= '0;
        oc_q    <= '0;
        swap_q  <= 1'b0;
        carry_q <= eff_sub;
        nan_q   <= 1'b1;
        neg_q   <= 1'b0;
        if (!(nanin_q || op_q > OP_REM || ((op_q inside {OP_DIV, OP_REM}) && bzero))) begin
          nan_q <= 1'b0;
          case (op_q)
            OP_ADD, OP_SUB: neg_q <= an_q;
            OP_REM:         neg_q <= an_q;
            default:        neg_q <= an_q ^ bn_q;
          endcase
        end
      end
      S_ADD, S_ADD2: begin
        wa_q    <= {wa_q[WordW-1:0], wa_q[TotW-1:WordW]};
        wb_q    <= {wb_q[WordW-1:0], wb_q[TotW-1:WordW]};
        res_q   <= {sum[WordW-1:0], res_q[TotW-1:WordW]};
        carry_q <= sum[WordW];
        cnt_q   <= cnt_q + 1'b1;
        if (cnt_q == DW'(OPERAND_WORDS - 1)) begin
          cnt_q   <= '0;
          carry_q <= 1'b1;
          if (state_q == S_ADD && eff_sub && !sum[WordW]) begin
            // |b| > |a|: redo as b - a with b's effective sign
            swap_q <= 1'b1;
            neg_q  <= bn_q ^ (op_q == OP_SUB);
          end else if (!eff_sub && sum[WordW]) begin
            nan_q <= 1'b1;
          end
        end
      end
      S_MUL: begin
        if (issue_q) begin
          if (mac_ctl.col_end) begin
            li_q  <= '0;
            col_q <= col_q + 1'b1;
          end else begin
            li_q <= li_q + 1'b1;
          end
        end
        if (limb_valid) begin
          oc_q <= oc_q + 1'b1;
          if (oc_q < CW'(LimbN)) res_q <= {limb, res_q[TotW-1:LimbW]};
          else if (|limb) nan_q <= 1'b1;
        end
      end
      S_DIV:    cnt_q <= cnt_q + 1'b1;
      S_DIVOUT: begin
        res_q <= (op_q == OP_DIV) ? quo : remd;
        cnt_q <= '0;
      end
      S_FIN: begin
        cnt_q <= '0;
        if (~|res_q) neg_q <= 1'b0;
      end
      S_EMIT: begin
        res_q <= {WordW'(0), res_q[TotW-1:WordW]};
        cnt_q <= cnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  assign valid_o           = (state_q == S_EMIT);
  assign result_word_o     = res_q[WordW-1:0];
  assign result_negative_o = neg_q;
  assign result_nan_o      = nan_q;
  assign last_out_o        = valid_o && (cnt_q == DW'(OPERAND_WORDS - 1));

endmodule

FILE: rtl/core/smw_checker.sv
// Port-level checks for the sign-magnitude wide ALU, bound to the top level.
// Depends on sign_magnitude_wide_alu's ports only.
module smw_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic busy,
  input logic valid_o,
  input logic last_out_o,
  input logic result_negative_o,
  input logic result_nan_o
);

  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy) else $error("result word outside busy window");

  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_out_o |-> valid_o) else $error("last_out without valid");

  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_out_o |=> valid_o) else $error("result burst broken");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_out_o |=> $stable(result_nan_o) && $stable(result_negative_o))
    else $error("sign or nan changed within one item");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_out_o |=> !valid_o) else $error("result word after last");

endmodule

bind sign_magnitude_wide_alu smw_checker u_smw_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .busy              (busy),
  .valid_o           (valid_o),
  .last_out_o        (last_out_o),
  .result_negative_o (result_negative_o),
  .result_nan_o      (result_nan_o)
);
